// ===== rtl/core/assert_macros.svh =====
// Assertion helper macros for the RTL files; two_level_page_table_unit includes them.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Plain property check.
`define TLPT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication with the consequent in the cycle after the antecedent.
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/tlpt_pkg.sv =====
// Package for the two-level page table unit: sizes, modes, beat structs.
// No dependencies.
`timescale 1ns / 1ps
package tlpt_pkg;
  localparam int unsigned DIR_SLOTS   = 64;
  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned DIR_BITS    = $clog2(DIR_SLOTS);
  localparam int unsigned TBL_BITS    = $clog2(TABLE_SLOTS);
  localparam int unsigned PAGE_BITS   = DIR_BITS + TBL_BITS;
  localparam int unsigned TOTAL_PAGES = DIR_SLOTS * TABLE_SLOTS;
  localparam int unsigned OFFSET_BITS = 12;
  localparam int unsigned FRAME_BITS  = 20;
  localparam int unsigned ENTRY_BITS  = FRAME_BITS + 3;
  localparam int unsigned CNT_BITS    = 18;

  typedef enum logic [2:0] {
    MODE_XLATE = 3'd0,
    MODE_QUERY = 3'd1,
    MODE_MAP   = 3'd2,
    MODE_UNMAP = 3'd3,
    MODE_FIND  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] virt_page;
    logic [11:0] page_offset;
    logic [19:0] phys_frame;
    logic        want_write;
    logic        want_user;
    logic [15:0] range_start_page;
    logic [16:0] range_end_page;
    logic [16:0] page_count;
  } in_t;

  typedef struct packed {
    logic [31:0] phys_addr;
    logic        ok;
    logic        can_read;
    logic        can_exec;
    logic        can_write;
    logic        user_access;
    logic        kernel_access;
    logic [15:0] found_page;
  } out_t;
endpackage

// ===== rtl/core/tlpt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tlpt_ram #(
  parameter int unsigned DEPTH  = 65536,
  parameter int unsigned DATA_W = 23,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/core/tlpt_alu.sv =====
// Shared run-count adder and threshold compare for the free-run walk.
// Depends on tlpt_pkg.
`timescale 1ns / 1ps
module tlpt_alu (
  input  logic [tlpt_pkg::CNT_BITS-1:0] a_i,
  input  logic [tlpt_pkg::CNT_BITS-1:0] b_i,
  input  logic [16:0]                   lim_i,
  output logic [tlpt_pkg::CNT_BITS-1:0] sum_o,
  output logic                          ge_o
);
  import tlpt_pkg::*;

  assign sum_o = a_i + b_i;
  assign ge_o  = sum_o >= CNT_BITS'(lim_i);
endmodule

// ===== rtl/core/two_level_page_table_unit.sv =====
// Top level of the two-level page table unit.
// Depends on tlpt_pkg, tlpt_ram, tlpt_alu and assert_macros.svh.
//
// Usage:
//  - Input channel in_valid_i / in_ready_o / in_data_i carries one request
//    beat: mode plus its operands. Output channel out_valid_o / out_ready_i /
//    out_data_o returns exactly one result beat per request, in order.
//  - One request at a time: in_ready_o is high only when the sequencer idles.
//  - Map goes from the input beat straight to the push state; translate,
//    query, unmap and unknown modes pass through a lookup state first (one
//    page-table RAM read). in_ready_o is back once the result is pushed.
//  - Find walks the range one directory step at a time: an absent slot is
//    counted in a single step; a present slot is scanned page by page, each
//    page a RAM read, then a check through the shared count/compare unit. A
//    final step ends the walk once the range runs out; then it pushes.
//  - After reset all 65536 page-table RAM entries are swept to zero, one entry
//    a cycle; in_ready_o stays low meanwhile. Directory bits reset at once.
//  - The result sits in an output register. A new request is taken while it
//    waits; if the next result is done before the receiver takes the old
//    one, the sequencer holds it until the output register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module two_level_page_table_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tlpt_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tlpt_pkg::out_t out_data_o
);
  import tlpt_pkg::*;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_LOOK, S_FSTEP, S_FRD, S_FCHK, S_PUSH
  } state_e;

  state_e                state_q;
  logic [PAGE_BITS:0]    clr_q;
  logic [DIR_SLOTS-1:0]  dir_q;
  in_t                   req_q;
  out_t                  res_q;
  out_t                  out_q;
  logic                  out_valid_q;
  // walk registers
  logic [16:0]           i_q;
  logic [TBL_BITS-1:0]   j_q;
  logic [CNT_BITS-1:0]   c_q;
  logic [CNT_BITS-1:0]   p_q;
  logic [16:0]           end_q;

  logic                  in_fire;
  logic                  we;
  logic [PAGE_BITS-1:0]  waddr;
  logic [ENTRY_BITS-1:0] wdata;
  logic [PAGE_BITS-1:0]  raddr;
  logic [ENTRY_BITS-1:0] rdata;
  logic [16:0]           pg;
  logic                  first_dir;
  logic                  slot_ok;
  logic [CNT_BITS-1:0]   alu_a;
  logic [CNT_BITS-1:0]   alu_b;
  logic [CNT_BITS-1:0]   alu_sum;
  logic                  alu_ge;
  logic                  in_use;
  out_t                  res_init;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign pg        = i_q + 17'(j_q);
  assign first_dir = (i_q < 17'(TABLE_SLOTS));
  assign slot_ok   = dir_q[req_q.virt_page[PAGE_BITS-1:TBL_BITS]];
  assign in_use    = ((i_q == '0) && (j_q == '0)) || pg[16] || rdata[0];

  // map finishes at once with ok set; everything else starts from zero
  always_comb begin
    res_init    = '0;
    res_init.ok = (in_data_i.mode == MODE_MAP);
  end

  // absent slot adds a whole table (one less in the first), a free page adds one
  assign alu_a = c_q;
  assign alu_b = (state_q == S_FSTEP)
               ? (first_dir ? CNT_BITS'(TABLE_SLOTS - 1) : CNT_BITS'(TABLE_SLOTS))
               : CNT_BITS'(1);

  tlpt_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lim_i (req_q.page_count),
    .sum_o (alu_sum),
    .ge_o  (alu_ge)
  );

  // RAM port steering
  always_comb begin
    we    = 1'b0;
    waddr = in_data_i.virt_page;
    wdata = '0;
    raddr = in_data_i.virt_page;
    unique case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q[PAGE_BITS-1:0];
      end
      S_IDLE: begin
        if (in_fire && (in_data_i.mode == MODE_MAP)) begin
          we    = 1'b1;
          wdata = {in_data_i.phys_frame, in_data_i.want_user, in_data_i.want_write, 1'b1};
        end
      end
      S_LOOK: begin
        waddr = req_q.virt_page;
        we    = (req_q.mode == MODE_UNMAP) && slot_ok && rdata[0];
      end
      S_FRD: raddr = pg[PAGE_BITS-1:0];
      default: ;
    endcase
  end

  tlpt_ram #(
    .DEPTH  (TOTAL_PAGES),
    .DATA_W (ENTRY_BITS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      dir_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // the push state handles its own handoff
      if (out_valid_q && out_ready_i && (state_q != S_PUSH)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (PAGE_BITS+1)'(TOTAL_PAGES - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            req_q <= in_data_i;
            res_q <= res_init;
            i_q   <= 17'(in_data_i.range_start_page);
            p_q   <= CNT_BITS'(in_data_i.range_start_page);
            c_q   <= '0;
            end_q <= (in_data_i.range_end_page > 17'(TOTAL_PAGES))
                   ? 17'(TOTAL_PAGES) : in_data_i.range_end_page;
            if (in_data_i.mode == MODE_MAP) begin
              dir_q[in_data_i.virt_page[PAGE_BITS-1:TBL_BITS]] <= 1'b1;
              state_q  <= S_PUSH;
            end else if (in_data_i.mode == MODE_FIND) begin
              state_q <= S_FSTEP;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          if (slot_ok) begin
            case (req_q.mode)
              MODE_XLATE: res_q.phys_addr <= {rdata[ENTRY_BITS-1:3], req_q.page_offset};
              MODE_QUERY: begin
                if (rdata[0]) begin
                  res_q.can_read      <= 1'b1;
                  res_q.can_exec      <= 1'b1;
                  res_q.kernel_access <= 1'b1;
                  res_q.can_write     <= rdata[1];
                  res_q.user_access   <= rdata[2];
                end
              end
              MODE_UNMAP: res_q.ok <= rdata[0];
              default: ;
            endcase
          end
          state_q <= S_PUSH;
        end
        S_FSTEP: begin
          if (i_q >= end_q) begin
            state_q <= S_PUSH;
          end else if (dir_q[i_q[PAGE_BITS-1:TBL_BITS]]) begin
            j_q     <= '0;
            state_q <= S_FRD;
          end else begin
            c_q <= alu_sum;
            if (first_dir) begin
              p_q <= p_q + 1'b1;
            end
            if (alu_ge) begin
              res_q.ok         <= 1'b1;
              res_q.found_page <= first_dir ? 16'(p_q + 1'b1) : p_q[15:0];
              state_q          <= S_PUSH;
            end else begin
              i_q <= i_q + 17'(TABLE_SLOTS);
            end
          end
        end
        S_FRD: state_q <= S_FCHK;
        S_FCHK: begin
          if (in_use) begin
            c_q <= '0;
            p_q <= CNT_BITS'(pg) + 1'b1;
          end else begin
            c_q <= alu_sum;
          end
          if (!in_use && alu_ge) begin
            res_q.ok         <= 1'b1;
            res_q.found_page <= p_q[15:0];
            state_q          <= S_PUSH;
          end else if (j_q == TBL_BITS'(TABLE_SLOTS - 1)) begin
            i_q     <= i_q + 17'(TABLE_SLOTS);
            state_q <= S_FSTEP;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= S_FRD;
          end
        end
        S_PUSH: begin
          if (!out_valid_q || out_ready_i) begin
            out_q       <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `TLPT_ASSERT(a_no_take_in_clear, (state_q == S_CLR) |-> !in_ready_o, "taken during clear")
  `TLPT_ASSERT_NEXT(a_map_sets_dir, in_fire && (in_data_i.mode == MODE_MAP),
    dir_q[$past(in_data_i.virt_page[PAGE_BITS-1:TBL_BITS])], "map left slot absent")
  `TLPT_ASSERT(a_chk_after_rd, (state_q == S_FCHK) |-> ($past(state_q) == S_FRD),
    "check without read")
endmodule
